/* rtl/agd_pkg.sv */
// ----------------------------------------------------------------------------
// agd_pkg
// shared types, field layouts, register codes and defaults of the
// accelerator group dispatcher
// ----------------------------------------------------------------------------
package agd_pkg;

   // member mask layout in the group mask register
   localparam int MASK_BITS   = 16;
   localparam int MASK_GROUPS = 4;

   // parameter defaults
   localparam int NUM_ACCELS_DEF = 16;
   localparam int NUM_GROUPS_DEF = 4;
   localparam int FIFO_DEPTH_DEF = 16;

   // field widths
   localparam int GROUP_W = 2;
   localparam int SLOT_W  = 4;
   localparam int ACCEL_W = 4;
   localparam int COUNT_W = 5;

   // stream and register port widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 64;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] GROUP_MASKS_RESET = 64'h1000_0F00_00F0_000F;
   localparam logic [COUNT_W-1:0]    SLOT_LIMIT_RESET  = 5'd16;

   // request kinds (req_tuser)
   localparam logic REQ_NEW  = 1'b0;
   localparam logic REQ_DONE = 1'b1;

   // register index, taken from the 8-byte word address
   localparam logic REG_GROUP_MASKS = 1'b0;
   localparam logic REG_SLOT_LIMIT  = 1'b1;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] group_masks;
      logic [COUNT_W-1:0]    slot_limit;
   } cfg_type;

   // request item fields, last field in the low bits
   typedef struct packed {
      logic [ACCEL_W-1:0] accel;
      logic [SLOT_W-1:0]  slot;
      logic [GROUP_W-1:0] group;
   } req_item_type;

   // result item fields, last field in the low bits
   typedef struct packed {
      logic [SLOT_W-1:0]  finished_slot;
      logic               finished_valid;
      logic               queued;
      logic [SLOT_W-1:0]  start_slot;
      logic [ACCEL_W-1:0] start_accel;
      logic               start_valid;
   } rsp_type;

endpackage

/* rtl/agd_csr.sv */
// ----------------------------------------------------------------------------
// agd_csr
// register file of the dispatcher: group member masks and slot count
// ----------------------------------------------------------------------------
module agd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [agd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [agd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [agd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output agd_pkg::cfg_type                cfg
);
   import agd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    reg_sel;

   // 8-byte registers, word address bit picks the register
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_GROUP_MASKS: cfg_in.group_masks = csr_pwdata;
            REG_SLOT_LIMIT:  cfg_in.slot_limit  = csr_pwdata[COUNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_GROUP_MASKS: csr_prdata = cfg_ff.group_masks;
         REG_SLOT_LIMIT:  csr_prdata = CSR_DATA_W'(cfg_ff.slot_limit);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.group_masks <= GROUP_MASKS_RESET;
         cfg_ff.slot_limit  <= SLOT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/agd_wait_mem.sv */
// ----------------------------------------------------------------------------
// agd_wait_mem
// waiting-slot storage of all groups, one write and one registered read
// port, a write to the address being read is forwarded
// ----------------------------------------------------------------------------
module agd_wait_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/accel_group_dispatcher_top.sv */
// ----------------------------------------------------------------------------
// accel_group_dispatcher_top
// hands packet slots to a pool of accelerators sorted into groups, with a
// waiting fifo for each group
// ----------------------------------------------------------------------------
//
//  port group  direction  role
//  req_*       in         new slot for a group, or accelerator finished
//  rsp_*       out        one result item for every request item
//  csr_*       in/out     group member masks and slot count
//
//  one item per cycle sustained while rsp is not stalled
//  item flow: input register -> dispatch logic -> result register
//  the fifo head is read from the wait memory while the item is accepted,
//  with pointers that already include the item ahead of it
//  synchronous active-high reset clears busy flags, pointers and valids
//  a stalled rsp holds the result register, and the input register then
//  holds its item and drops req_tready
//
module accel_group_dispatcher_top #(
   parameter int NUM_ACCELS = agd_pkg::NUM_ACCELS_DEF,
   parameter int NUM_GROUPS = agd_pkg::NUM_GROUPS_DEF,
   parameter int FIFO_DEPTH = agd_pkg::FIFO_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [agd_pkg::REQ_TDATA_W-1:0] req_tdata,  // group[1:0] slot[5:2] accel[9:6]
   input  logic                            req_tuser,  // req_type
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // start_valid[0] start_accel[4:1] start_slot[8:5] queued[9]
   // finished_valid[10] finished_slot[14:11]
   output logic [agd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [agd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [agd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [agd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import agd_pkg::*;

   // only the low mask bits and the first mask groups are reachable
   localparam int ACC_N     = (NUM_ACCELS < MASK_BITS) ? NUM_ACCELS : MASK_BITS;
   localparam int GRP_N     = (NUM_GROUPS < MASK_GROUPS) ? NUM_GROUPS : MASK_GROUPS;
   localparam int ACC_IW    = (ACC_N > 1) ? $clog2(ACC_N) : 1;
   localparam int GRP_IW    = (GRP_N > 1) ? $clog2(GRP_N) : 1;
   localparam int PTR_W     = $clog2(FIFO_DEPTH);
   localparam int WRAP_W    = ($clog2(FIFO_DEPTH + 1) > COUNT_W) ?
                              $clog2(FIFO_DEPTH + 1) : COUNT_W;
   localparam int MEM_DEPTH = GRP_N * FIFO_DEPTH;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   cfg_type cfg;

   agd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ------------------------------------------------------------------------
   // state
   // ------------------------------------------------------------------------
   logic [ACC_N-1:0]  busy_ff, busy_in;
   logic [SLOT_W-1:0] slot_of_accel_ff [ACC_N];
   logic [PTR_W-1:0]  wr_ptr_ff [GRP_N];
   logic [PTR_W-1:0]  wr_ptr_in [GRP_N];
   logic [PTR_W-1:0]  rd_ptr_ff [GRP_N];
   logic [PTR_W-1:0]  rd_ptr_in [GRP_N];
   logic [GRP_N-1:0]  waiting_ff, waiting_in;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   req_item_type      s1_item_ff;
   logic              s1_kind_ff;
   logic [GRP_IW-1:0] s1_grp_ff;
   logic              s1_found_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           result;

   logic advance;
   logic accept;

   // wait memory ports
   logic              mem_wr_en;
   logic [MEM_AW-1:0] mem_wr_addr;
   logic [SLOT_W-1:0] mem_wr_data;
   logic [MEM_AW-1:0] mem_rd_addr;
   logic [SLOT_W-1:0] mem_rd_data;

   // slot table write
   logic              sa_wr_en;
   logic [ACC_IW-1:0] sa_wr_idx;
   logic [SLOT_W-1:0] sa_wr_data;

   logic [WRAP_W-1:0] wrap;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0]  p,
                                                 input logic [WRAP_W-1:0] w);
      logic [WRAP_W-1:0] nx;
      nx = WRAP_W'(p) + WRAP_W'(1);
      return (nx >= w) ? '0 : PTR_W'(nx);
   endfunction

   function automatic logic [MEM_AW-1:0] mem_addr(input logic [GRP_IW-1:0] g,
                                                  input logic [PTR_W-1:0]  p);
      logic [MEM_AW:0] t;
      t = (MEM_AW+1)'(g) * (MEM_AW+1)'(FIFO_DEPTH) + (MEM_AW+1)'(p);
      return t[MEM_AW-1:0];
   endfunction

   // fifo wrap point: slot count clamped to 1..FIFO_DEPTH
   always_comb begin
      if (cfg.slot_limit == '0) begin
         wrap = WRAP_W'(1);
      end else if (WRAP_W'(cfg.slot_limit) > WRAP_W'(FIFO_DEPTH)) begin
         wrap = WRAP_W'(FIFO_DEPTH);
      end else begin
         wrap = WRAP_W'(cfg.slot_limit);
      end
   end

   // ------------------------------------------------------------------------
   // handshake
   // ------------------------------------------------------------------------
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   // ------------------------------------------------------------------------
   // lookup at acceptance: group of a finishing accelerator and its fifo head
   // ------------------------------------------------------------------------
   req_item_type      req_item;
   logic              req_acc_ok;
   logic [ACC_IW-1:0] req_acc_idx;
   logic              lk_found;
   logic [GRP_IW-1:0] lk_grp;
   logic [PTR_W-1:0]  lk_ptr;

   assign req_item    = req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
   assign req_acc_ok  = ({1'b0, req_item.accel} < (ACCEL_W+1)'(ACC_N));
   assign req_acc_idx = req_item.accel[ACC_IW-1:0];

   always_comb begin
      lk_found = 1'b0;
      lk_grp   = '0;
      // lowest group holding the accelerator wins
      for (int g = GRP_N - 1; g >= 0; g--) begin
         if (req_acc_ok && cfg.group_masks[MASK_BITS*g + int'(req_acc_idx)]) begin
            lk_found = 1'b1;
            lk_grp   = GRP_IW'(g);
         end
      end
      // read pointer after the item ahead has been dispatched
      lk_ptr = '0;
      for (int g = 0; g < GRP_N; g++) begin
         if (lk_grp == GRP_IW'(g)) begin
            lk_ptr = rd_ptr_in[g];
         end
      end
   end

   assign mem_rd_addr = mem_addr(lk_grp, lk_ptr);

   agd_wait_mem #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (MEM_AW),
      .DATA_W (SLOT_W)
   ) u_wait_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // ------------------------------------------------------------------------
   // dispatch of the registered item
   // ------------------------------------------------------------------------
   logic              new_grp_ok;
   logic [GRP_IW-1:0] new_grp;
   logic [ACC_N-1:0]  idle;
   logic [ACC_IW-1:0] idle_first;
   logic              done_ok;
   logic [ACC_IW-1:0] done_idx;
   logic              push_en;
   logic              pop_en;
   logic [PTR_W-1:0]  push_ptr;
   logic              pop_waiting;

   assign new_grp_ok = ({1'b0, s1_item_ff.group} < (GROUP_W+1)'(GRP_N));
   assign new_grp    = s1_item_ff.group[GRP_IW-1:0];
   assign done_idx   = s1_item_ff.accel[ACC_IW-1:0];
   assign done_ok    = ({1'b0, s1_item_ff.accel} < (ACCEL_W+1)'(ACC_N)) &&
                       busy_ff[done_idx];

   // idle members of the requested group, lowest index first
   always_comb begin
      for (int i = 0; i < ACC_N; i++) begin
         idle[i] = cfg.group_masks[MASK_BITS*int'(s1_item_ff.group) + i] && !busy_ff[i];
      end
      idle_first = '0;
      for (int i = ACC_N - 1; i >= 0; i--) begin
         if (idle[i]) begin
            idle_first = ACC_IW'(i);
         end
      end
   end

   // per-group selects
   always_comb begin
      push_ptr    = '0;
      pop_waiting = 1'b0;
      for (int g = 0; g < GRP_N; g++) begin
         if (new_grp == GRP_IW'(g)) begin
            push_ptr = wr_ptr_ff[g];
         end
         if (s1_grp_ff == GRP_IW'(g)) begin
            pop_waiting = waiting_ff[g];
         end
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      result      = '0;
      sa_wr_en    = 1'b0;
      sa_wr_idx   = done_idx;
      sa_wr_data  = s1_item_ff.slot;
      push_en     = 1'b0;
      pop_en      = 1'b0;
      if (advance) begin
         if (s1_kind_ff == REQ_NEW) begin
            if (new_grp_ok) begin
               if (|idle) begin
                  busy_in[idle_first] = 1'b1;
                  sa_wr_en            = 1'b1;
                  sa_wr_idx           = idle_first;
                  result.start_valid  = 1'b1;
                  result.start_accel  = ACCEL_W'(idle_first);
                  result.start_slot   = s1_item_ff.slot;
               end else begin
                  // no idle member: wait in the group fifo, even if it is full
                  push_en       = 1'b1;
                  result.queued = 1'b1;
               end
            end
         end else if (done_ok) begin
            busy_in[done_idx]     = 1'b0;
            result.finished_valid = 1'b1;
            result.finished_slot  = slot_of_accel_ff[done_idx];
            // restart the oldest waiting slot of its group on it
            if (s1_found_ff && pop_waiting) begin
               pop_en             = 1'b1;
               busy_in[done_idx]  = 1'b1;
               sa_wr_en           = 1'b1;
               sa_wr_data         = mem_rd_data;
               result.start_valid = 1'b1;
               result.start_accel = s1_item_ff.accel;
               result.start_slot  = mem_rd_data;
            end
         end
      end
   end

   assign mem_wr_en   = push_en;
   assign mem_wr_addr = mem_addr(new_grp, push_ptr);
   assign mem_wr_data = s1_item_ff.slot;

   // fifo pointers and waiting flags, one lane per group
   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         wr_ptr_in[g]  = wr_ptr_ff[g];
         rd_ptr_in[g]  = rd_ptr_ff[g];
         waiting_in[g] = waiting_ff[g];
         if (push_en && (new_grp == GRP_IW'(g))) begin
            wr_ptr_in[g]  = ptr_next(wr_ptr_ff[g], wrap);
            waiting_in[g] = 1'b1;
         end
         if (pop_en && (s1_grp_ff == GRP_IW'(g))) begin
            rd_ptr_in[g] = ptr_next(rd_ptr_ff[g], wrap);
            if (rd_ptr_in[g] == wr_ptr_ff[g]) begin
               waiting_in[g] = 1'b0;
            end
         end
      end
   end

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   // ------------------------------------------------------------------------
   // clocked state
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= '0;
         waiting_ff   <= '0;
         for (int g = 0; g < GRP_N; g++) begin
            wr_ptr_ff[g] <= '0;
            rd_ptr_ff[g] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         waiting_ff   <= waiting_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
      end
   end

   // item payload, loaded on acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff  <= req_item;
         s1_kind_ff  <= req_tuser;
         s1_grp_ff   <= lk_grp;
         s1_found_ff <= lk_found;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   // slot held by each busy accelerator
   always_ff @(posedge clock) begin
      if (sa_wr_en) begin
         slot_of_accel_ff[sa_wr_idx] <= sa_wr_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

endmodule

/* rtl/agd_checker.sv */
// ----------------------------------------------------------------------------
// agd_checker
// port-level checks of the dispatcher, bound to the top level
// ----------------------------------------------------------------------------
module agd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [agd_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import agd_pkg::*;

   rsp_type rsp_f;

   assign rsp_f = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // reset empties both registers
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // input back-pressure only comes from a stalled result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without rsp stall");

   // unused start and finish fields read as zero
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_f.start_valid || (rsp_f.start_accel == '0 && rsp_f.start_slot == '0))
                  && (rsp_f.finished_valid || rsp_f.finished_slot == '0))
      else $error("inactive rsp field not zero");

   // a queued slot is neither started nor a finish
   a_queued_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_f.queued |-> !rsp_f.start_valid && !rsp_f.finished_valid)
      else $error("queued with start or finish");

endmodule

bind accel_group_dispatcher_top agd_checker u_agd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* verif/accel_group_dispatcher_checker.sv */
// ----------------------------------------------------------------------------
// accel_group_dispatcher_checker
// watches the request, result and register ports of the dispatcher, keeps
// its own copy of accelerator, slot and waiting-fifo state, and compares
// every result item with the one predicted for the oldest request
// ----------------------------------------------------------------------------
module accel_group_dispatcher_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [agd_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                               req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [agd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic                               csr_pready,
   input  logic [agd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [agd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output int                                 mismatches,
   output int                                 outstanding,
   output logic [agd_pkg::NUM_ACCELS_DEF-1:0] model_busy,
   output logic [agd_pkg::NUM_GROUPS_DEF-1:0] model_waiting
);
   import agd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ACCELS = NUM_ACCELS_DEF;
   localparam int GROUPS = NUM_GROUPS_DEF;
   localparam int DEPTH  = FIFO_DEPTH_DEF;
   localparam int REPORT_LIMIT = 10;

   // configuration as seen on the register port
   logic [CSR_DATA_W-1:0] member_masks;
   logic [COUNT_W-1:0]    slot_limit;

   // dispatcher state
   logic [ACCELS-1:0] accel_busy;
   logic [SLOT_W-1:0] accel_slot [ACCELS];
   logic [SLOT_W-1:0] wait_slots [GROUPS][DEPTH];
   logic [SLOT_W-1:0] wr_ptr [GROUPS];
   logic [SLOT_W-1:0] rd_ptr [GROUPS];
   logic [GROUPS-1:0] group_waiting;

   rsp_type owed_results[$];
   int      fail_count;
   int      result_index;

   function automatic logic [MASK_BITS-1:0] group_members(int g);
      return member_masks[MASK_BITS*g +: MASK_BITS];
   endfunction

   // 0 behaves as 1, anything above the fifo depth as the depth
   function automatic int wrap_point();
      int c;
      c = int'(slot_limit);
      if (c == 0) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic logic [SLOT_W-1:0] next_ptr(logic [SLOT_W-1:0] p);
      int n;
      n = int'(p) + 1;
      return (n >= wrap_point()) ? '0 : SLOT_W'(n);
   endfunction

   function automatic rsp_type dispatch_request(logic kind, req_item_type item);
      rsp_type                r;
      logic [ACCELS-1:0]      idle;
      logic [MASK_BITS-1:0]   members;
      logic [SLOT_W-1:0]      popped;
      int                     pick;
      int                     home;
      int                     a;
      int                     g;
      r = '0;
      if (kind == REQ_NEW) begin
         g = int'(item.group);
         idle = group_members(g) & ~accel_busy;
         if (idle != '0) begin
            pick = 0;
            for (int k = ACCELS - 1; k >= 0; k--) if (idle[k]) pick = k;
            accel_busy[pick] = 1'b1;
            accel_slot[pick] = item.slot;
            r.start_valid = 1'b1;
            r.start_accel = ACCEL_W'(pick);
            r.start_slot  = item.slot;
         end else begin
            // a full fifo simply overwrites its oldest entry
            wait_slots[g][wr_ptr[g]] = item.slot;
            wr_ptr[g] = next_ptr(wr_ptr[g]);
            group_waiting[g] = 1'b1;
            r.queued = 1'b1;
         end
      end else begin
         a = int'(item.accel);
         if (accel_busy[a]) begin
            accel_busy[a] = 1'b0;
            r.finished_valid = 1'b1;
            r.finished_slot  = accel_slot[a];
            // lowest group holding the accelerator is its home
            home = GROUPS;
            for (int k = GROUPS - 1; k >= 0; k--) begin
               members = group_members(k);
               if (members[a]) home = k;
            end
            if (home < GROUPS && group_waiting[home]) begin
               popped = wait_slots[home][rd_ptr[home]];
               rd_ptr[home] = next_ptr(rd_ptr[home]);
               if (wr_ptr[home] == rd_ptr[home]) group_waiting[home] = 1'b0;
               accel_busy[a] = 1'b1;
               accel_slot[a] = popped;
               r.start_valid = 1'b1;
               r.start_accel = ACCEL_W'(a);
               r.start_slot  = popped;
            end
         end
      end
      return r;
   endfunction

   function automatic string show(rsp_type r);
      return $sformatf("start %0d accel %0d slot %0d queued %0d finished %0d slot %0d",
                       r.start_valid, r.start_accel, r.start_slot, r.queued,
                       r.finished_valid, r.finished_slot);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      logic    differs;
      if (reset) begin
         member_masks  = GROUP_MASKS_RESET;
         slot_limit    = SLOT_LIMIT_RESET;
         accel_busy    = '0;
         group_waiting = '0;
         foreach (accel_slot[i]) accel_slot[i] = '0;
         foreach (wait_slots[i, j]) wait_slots[i][j] = '0;
         foreach (wr_ptr[i]) begin
            wr_ptr[i] = '0;
            rd_ptr[i] = '0;
         end
         owed_results.delete();
         fail_count   = 0;
         result_index = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[3] == REG_GROUP_MASKS) member_masks = csr_pwdata;
            else slot_limit = csr_pwdata[COUNT_W-1:0];
         end
         // results first: a result never belongs to an item accepted at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (owed_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("result %0d arrived with nothing expected: %s",
                           result_index, show(got));
            end else begin
               want = owed_results.pop_front();
               differs = (got.start_valid    !== want.start_valid)
                      || (got.start_accel    !== want.start_accel)
                      || (got.start_slot     !== want.start_slot)
                      || (got.queued         !== want.queued)
                      || (got.finished_valid !== want.finished_valid)
                      || (got.finished_slot  !== want.finished_slot);
               if (differs) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("result %0d mismatch: expected %s, got %s",
                              result_index, show(want), show(got));
               end
            end
            result_index++;
         end
         if (req_tvalid && req_tready)
            owed_results.push_back(dispatch_request(req_tuser,
               req_item_type'(req_tdata[$bits(req_item_type)-1:0])));
      end
      mismatches    <= fail_count;
      outstanding   <= owed_results.size();
      model_busy    <= accel_busy;
      model_waiting <= group_waiting;
   end

endmodule

/* verif/accel_group_dispatcher_top_test.sv */
// ----------------------------------------------------------------------------
// accel_group_dispatcher_top_test
// drives slot requests and accelerator-done items into the dispatcher under
// a series of group mask and slot count settings, with random gaps on the
// request side and random stalls on the result side; a separate checker
// predicts and compares every result item
// ----------------------------------------------------------------------------
module accel_group_dispatcher_top_test;
   import agd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS_PER_PHASE = 190;
   localparam int PHASES          = 6;
   localparam int CYCLE_LIMIT     = 300000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int                        mismatches;
   int                        outstanding;
   logic [NUM_ACCELS_DEF-1:0] model_busy;
   logic [NUM_GROUPS_DEF-1:0] model_waiting;

   // percent of cycles in which the sender holds back / the receiver stalls
   int src_gap_pct;
   int sink_stall_pct;
   int cycle_count;

   accel_group_dispatcher_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   accel_group_dispatcher_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .model_busy    (model_busy),
      .model_waiting (model_waiting)
   );

   always #5ns clock = ~clock;

   // result side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // offers one item and returns at the edge where it is taken;
   // tvalid stays high so back-to-back items need no gap
   task automatic push_request(logic kind, logic [GROUP_W-1:0] grp,
                               logic [SLOT_W-1:0] slt, logic [ACCEL_W-1:0] acc);
      req_item_type item;
      item.group = grp;
      item.slot  = slt;
      item.accel = acc;
      while ($urandom_range(99) < src_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(item);
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
   endtask

   // drops tvalid and waits until every result has come back; the edge in
   // front of the loop lets the count catch up with the last acceptance
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // setup cycle, then access cycle; the register takes the value at the
   // edge that closes the access cycle
   task automatic write_register(logic reg_sel, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // empties every waiting fifo and frees every accelerator so the slot
   // count can change without a pop landing on a stale fifo entry;
   // the reset masks give each group at least one member
   task automatic drain_groups();
      logic [NUM_ACCELS_DEF-1:0] snapshot;
      logic [MASK_BITS-1:0]      members;
      settle();
      write_register(REG_GROUP_MASKS, GROUP_MASKS_RESET);
      while (1) begin
         settle();
         if (model_busy == '0 && model_waiting == '0) break;
         snapshot = model_busy;
         // a waiting group with every member idle needs one start so a
         // later done item can pull its fifo
         for (int g = 0; g < NUM_GROUPS_DEF; g++) begin
            members = GROUP_MASKS_RESET[MASK_BITS*g +: MASK_BITS];
            if (model_waiting[g] && (members & snapshot) == '0)
               push_request(REQ_NEW, GROUP_W'(g), SLOT_W'($urandom_range(15)), '0);
         end
         for (int a = 0; a < NUM_ACCELS_DEF; a++)
            if (snapshot[a]) push_request(REQ_DONE, '0, '0, ACCEL_W'(a));
      end
   endtask

   // mostly meaningful traffic: new slots on random groups and done items
   // for accelerators that are busy; the rest are done items at random,
   // most of which land on idle accelerators and are dropped
   task automatic push_random_request();
      int                 pick;
      logic [ACCEL_W-1:0] target;
      pick   = $urandom_range(99);
      target = ACCEL_W'($urandom_range(15));
      if (pick < 48) begin
         push_request(REQ_NEW, GROUP_W'($urandom_range(3)), SLOT_W'($urandom_range(15)),
                      target);
      end else begin
         if (pick < 90 && model_busy != '0)
            while (!model_busy[target]) target = target + 1'b1;
         push_request(REQ_DONE, GROUP_W'($urandom_range(3)), SLOT_W'($urandom_range(15)),
                      target);
      end
   endtask

   task automatic set_idling(int mode);
      unique case (mode)
         0: begin
            src_gap_pct    = 26;
            sink_stall_pct = 51;
         end
         1: begin
            src_gap_pct    = 51;
            sink_stall_pct = 26;
         end
         default: begin
            src_gap_pct    = 0;
            sink_stall_pct = 0;
         end
      endcase
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] masks;
      logic [COUNT_W-1:0]    count;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = REQ_NEW;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cycle_count = 0;
      set_idling(0);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed, reset masks: groups own accels 0-3, 4-7, 8-11 and 12 ----
      // single-member group: one start, two slots queued, then popped in order
      push_request(REQ_NEW, 2'd3, 4'd15, 4'd0);
      push_request(REQ_NEW, 2'd3, 4'd1, 4'd0);
      push_request(REQ_NEW, 2'd3, 4'd2, 4'd0);
      push_request(REQ_DONE, 2'd0, 4'd0, 4'd12);
      push_request(REQ_DONE, 2'd0, 4'd0, 4'd12);
      push_request(REQ_DONE, 2'd0, 4'd0, 4'd12);
      // done for an idle accelerator, and for one that no group holds
      push_request(REQ_DONE, 2'd0, 4'd0, 4'd12);
      push_request(REQ_DONE, 2'd3, 4'd15, 4'd15);
      push_request(REQ_NEW, 2'd0, 4'd0, 4'd0);
      push_request(REQ_NEW, 2'd1, 4'd15, 4'd15);
      push_request(REQ_DONE, 2'd0, 4'd0, 4'd0);
      // all masks empty: busy accel 4 is freed without a restart, and a new
      // slot queues in a group that has no members
      settle();
      write_register(REG_GROUP_MASKS, '0);
      push_request(REQ_DONE, 2'd0, 4'd0, 4'd4);
      push_request(REQ_NEW, 2'd1, 4'd6, 4'd0);
      drain_groups();

      // ---- directed, overlapping masks and a zero slot count ----
      // group 0 = accels 0,15; group 1 = accels 1,15; group 2 empty;
      // group 3 = everyone; accel 15 belongs to group 0 since lowest wins
      write_register(REG_GROUP_MASKS, 64'hFFFF_0000_8002_8001);
      write_register(REG_SLOT_LIMIT, '0);
      // fifo of one entry: the second slot overwrites the first
      push_request(REQ_NEW, 2'd2, 4'd7, 4'd0);
      push_request(REQ_NEW, 2'd2, 4'd9, 4'd0);
      push_request(REQ_NEW, 2'd1, 4'd3, 4'd0);
      push_request(REQ_NEW, 2'd1, 4'd4, 4'd0);
      push_request(REQ_NEW, 2'd1, 4'd5, 4'd0);
      // accel 15 is freed into group 0, so group 1's waiting slot stays put
      push_request(REQ_DONE, 2'd0, 4'd0, 4'd15);
      push_request(REQ_DONE, 2'd0, 4'd0, 4'd1);
      push_request(REQ_NEW, 2'd3, 4'd10, 4'd0);

      // ---- random phases, each under its own setting ----
      for (int phase = 0; phase < PHASES; phase++) begin
         set_idling(phase / 2);
         drain_groups();
         unique case (phase)
            0: begin
               masks = GROUP_MASKS_RESET;
               count = 5'd3;
            end
            1: begin
               // every group holds every accelerator, count above the depth
               masks = '1;
               count = 5'd31;
            end
            2: begin
               // random split, some accelerators in no group at all
               masks = '0;
               for (int a = 0; a < NUM_ACCELS_DEF; a++) begin
                  int g;
                  g = $urandom_range(4);
                  if (g < MASK_GROUPS) masks[MASK_BITS*g + a] = 1'b1;
               end
               count = 5'd1;
            end
            3: begin
               // two empty groups and accel 15 left out
               masks = 64'h0000_00FF_0000_7F00;
               count = 5'd0;
            end
            4: begin
               masks = {$urandom, $urandom};
               count = COUNT_W'($urandom_range(31));
            end
            default: begin
               // one member per group, so queues build up quickly
               masks = 64'h8000_0400_0020_0001;
               count = 5'd16;
            end
         endcase
         write_register(REG_GROUP_MASKS, masks);
         write_register(REG_SLOT_LIMIT, CSR_DATA_W'(count));
         repeat (ITEMS_PER_PHASE) push_random_request();
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
